FILE: src/mbdc_pkg.sv
// Shared types and constants for the multi-buffer dirty chunk tracker.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mbdc_pkg;

   // Chunk and buffer geometry.
   localparam int NUM_CHUNKS = 64;
   localparam int CHUNK_W    = $clog2(NUM_CHUNKS);
   localparam int NUM_BUFS   = 4;
   localparam int BUF_W      = $clog2(NUM_BUFS);

   // Register and result field widths.
   localparam int CFG_W    = 7;
   localparam int BUFCNT_W = 3;
   localparam int COUNT_W  = 7;
   localparam int SRC_W    = 17;
   localparam int DST_W    = 19;
   localparam int HALF_W   = 6;
   localparam int PPC_W    = 12;
   localparam int CURCC_W  = 8;

   // Upper bounds of the configuration registers.
   localparam logic [CFG_W-1:0]    CHUNK_MAX  = 7'd64;
   localparam logic [CFG_W-1:0]    BATCH_MAX  = 7'd64;
   localparam logic [CFG_W-1:0]    VERTS_MAX  = 7'd64;
   localparam logic [BUFCNT_W-1:0] BUFCNT_MAX = 3'd4;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_CHUNK_COUNT = 2'd0,
      REG_BATCHES     = 2'd1,
      REG_VERTS       = 2'd2,
      REG_BUF_COUNT   = 2'd3
   } reg_index_type;

   // Configuration values in use, already saturated into range.
   typedef struct packed {
      logic [CFG_W-1:0]    chunk_count;
      logic [CFG_W-1:0]    batches_per_chunk;
      logic [CFG_W-1:0]    vertices_per_batch;
      logic [BUFCNT_W-1:0] buffer_count;
   } cfg_type;

   // Access to the dirty-bit store: one read and one write port.
   typedef struct packed {
      logic                rd_en;
      logic [CHUNK_W-1:0]  rd_addr;
      logic                wr_en;
      logic [CHUNK_W-1:0]  wr_addr;
      logic [NUM_BUFS-1:0] wr_data;
   } mem_req_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK_WR,
      ST_REJECT,
      ST_SETUP,
      ST_BASE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

FILE: src/mbdc_dirty_store.sv
// Dirty-bit store: one entry per chunk holding one bit per frame buffer.
// Synchronous memory with registered read; uses mbdc_pkg.
`default_nettype none

module mbdc_dirty_store
   import mbdc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire mem_req_type         mem_req,
   output      logic [NUM_BUFS-1:0] rd_data
);

   logic [NUM_BUFS-1:0] dirty_mem [NUM_CHUNKS];
   logic [NUM_CHUNKS-1:0] valid_ff;
   logic [NUM_BUFS-1:0] rd_raw_ff;
   logic                rd_valid_ff;

   // Memory array: write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         dirty_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_raw_ff <= dirty_mem[mem_req.rd_addr];
      end
   end

   // Written flags. An entry not written since reset or setup reads as all dirty.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr];
         end
         if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '1;

endmodule

`default_nettype wire

FILE: src/mbdc_cfg.sv
// Configuration registers with saturation into each register's range.
// Uses mbdc_pkg; feeds the sequencer and clears the dirty-bit store on setup.
`default_nettype none

module mbdc_cfg
   import mbdc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata,
   output      cfg_type          cfg,
   output      logic             setup_clear
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Saturate a seven-bit value into one to the given bound.
   function automatic logic [CFG_W-1:0] sat7(logic [CFG_W-1:0] v, logic [CFG_W-1:0] hi);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = 7'd1;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Register write decode.
   always_comb begin
      logic [BUFCNT_W-1:0] bc;
      bc     = csr_wdata[BUFCNT_W-1:0];
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_CHUNK_COUNT: cfg_in.chunk_count        = sat7(csr_wdata, CHUNK_MAX);
            REG_BATCHES:     cfg_in.batches_per_chunk  = sat7(csr_wdata, BATCH_MAX);
            REG_VERTS:       cfg_in.vertices_per_batch = sat7(csr_wdata, VERTS_MAX);
            REG_BUF_COUNT: begin
               if (bc == '0) begin
                  cfg_in.buffer_count = 3'd1;
               end else if (bc > BUFCNT_MAX) begin
                  cfg_in.buffer_count = BUFCNT_MAX;
               end else begin
                  cfg_in.buffer_count = bc;
               end
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_count        <= 7'd1;
         cfg_ff.batches_per_chunk  <= 7'd1;
         cfg_ff.vertices_per_batch <= 7'd1;
         cfg_ff.buffer_count       <= 3'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg         = cfg_ff;
   // Every register index is in the list, so every write is a fresh setup.
   assign setup_clear = csr_wr_en;

endmodule

`default_nettype wire

FILE: src/mbdc_ctrl.sv
// Sequencer: mark read-modify-write, frame scan over the dirty-bit store and the
// result register. Uses mbdc_pkg; drives the store's ports.
`default_nettype none

module mbdc_ctrl
   import mbdc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic                req_mode,
   input  wire logic [7:0]          req_chunk,
   input  wire logic [7:0]          req_buffer_index,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic                rsp_accepted,
   output      logic                rsp_copy_valid,
   output      logic [CHUNK_W-1:0]  rsp_chunk_index,
   output      logic [SRC_W-1:0]    rsp_source_offset,
   output      logic [DST_W-1:0]    rsp_dest_offset,
   output      logic [COUNT_W-1:0]  rsp_copied_count,
   output      logic                rsp_last,
   output      mem_req_type         mem_req,
   input  wire logic [NUM_BUFS-1:0] rd_data
);

   state_type state_ff, state_in;

   // Latched item and per-frame values.
   logic [CHUNK_W-1:0] chunk_ff;
   logic [7:0]         bidx_ff;
   logic [BUF_W-1:0]   cur_ff;
   logic [PPC_W-1:0]   ppc_ff;
   logic [CURCC_W-1:0] curcc_ff;

   // Scan position and running offsets of the chunk under test.
   logic [CHUNK_W-1:0] idx_ff;
   logic [SRC_W-1:0]   src_ff;
   logic [DST_W-1:0]   dst_ff;
   logic [COUNT_W-1:0] count_ff;

   // One copy command held back until it is known whether it is the final one.
   logic               pend_vld_ff;
   logic [CHUNK_W-1:0] pend_idx_ff;
   logic [SRC_W-1:0]   pend_src_ff;
   logic [DST_W-1:0]   pend_dst_ff;
   logic [COUNT_W-1:0] pend_cnt_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic               out_acc_ff, out_cv_ff, out_last_ff;
   logic [CHUNK_W-1:0] out_idx_ff;
   logic [SRC_W-1:0]   out_src_ff;
   logic [DST_W-1:0]   out_dst_ff;
   logic [COUNT_W-1:0] out_cnt_ff;

   logic               load_out;
   logic               out_acc_in, out_cv_in, out_last_in;
   logic [CHUNK_W-1:0] out_idx_in;
   logic [SRC_W-1:0]   out_src_in;
   logic [DST_W-1:0]   out_dst_in;
   logic [COUNT_W-1:0] out_cnt_in;

   logic                req_acc, in_range, out_free, dirty, scan_hold, scan_end, scan_step;
   logic [NUM_BUFS-1:0] buf_mask;
   logic [BUF_W-1:0]    cur_calc;
   logic [HALF_W-1:0]   half_verts;
   logic [PPC_W-1:0]    ppc_calc;

   // Requested buffer reduced modulo the buffer count (one to four).
   function automatic logic [BUF_W-1:0] reduce_index(logic [7:0] idx,
                                                     logic [BUFCNT_W-1:0] cnt);
      logic [3:0] digit_sum;
      logic [2:0] fold;
      logic [1:0] rem3;
      logic [BUF_W-1:0] r;
      // Four is one modulo three, so base-four digits sum to the same residue.
      digit_sum = 4'(idx[1:0]) + 4'(idx[3:2]) + 4'(idx[5:4]) + 4'(idx[7:6]);
      fold      = 3'(digit_sum[1:0]) + 3'(digit_sum[3:2]);
      if (fold >= 3'd6) begin
         rem3 = 2'(fold - 3'd6);
      end else if (fold >= 3'd3) begin
         rem3 = 2'(fold - 3'd3);
      end else begin
         rem3 = 2'(fold);
      end
      case (cnt)
         3'd2:    r = BUF_W'(idx[0]);
         3'd3:    r = BUF_W'(rem3);
         3'd4:    r = idx[BUF_W-1:0];
         default: r = '0;
      endcase
      return r;
   endfunction

   assign req_acc  = req_valid && !req_stall;
   assign in_range = req_chunk < {1'b0, cfg.chunk_count};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign dirty    = rd_data[cur_ff];
   // A second dirty chunk needs the held command moved out first.
   assign scan_hold = dirty && pend_vld_ff && !out_free;
   assign scan_end  = {1'b0, idx_ff} == (cfg.chunk_count - 7'd1);
   assign scan_step = (state_ff == ST_SCAN) && !scan_hold;

   assign cur_calc   = reduce_index(bidx_ff, cfg.buffer_count);
   assign half_verts = HALF_W'((cfg.vertices_per_batch + 7'd1) >> 1);
   assign ppc_calc   = PPC_W'(PPC_W'(half_verts) * PPC_W'(cfg.batches_per_chunk));

   // Buffers in use take a mark.
   always_comb begin
      for (int b = 0; b < NUM_BUFS; b++) begin
         buf_mask[b] = BUFCNT_W'(b) < cfg.buffer_count;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_mode) begin
                  state_in = ST_SETUP;
               end else if (in_range) begin
                  state_in = ST_MARK_WR;
               end else begin
                  state_in = ST_REJECT;
               end
            end
         end
         ST_MARK_WR: if (out_free) state_in = ST_IDLE;
         ST_REJECT:  if (out_free) state_in = ST_IDLE;
         ST_SETUP:   state_in = ST_BASE;
         ST_BASE:    state_in = ST_SCAN;
         ST_SCAN:    if (scan_step && scan_end) state_in = ST_FLUSH;
         ST_FLUSH:   if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Memory accesses and result loads.
   always_comb begin
      mem_req     = '0;
      load_out    = 1'b0;
      out_acc_in  = 1'b1;
      out_cv_in   = 1'b0;
      out_idx_in  = '0;
      out_src_in  = '0;
      out_dst_in  = '0;
      out_cnt_in  = '0;
      out_last_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && !req_mode && in_range) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = req_chunk[CHUNK_W-1:0];
            end
         end
         ST_MARK_WR: begin
            if (out_free) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = chunk_ff;
               mem_req.wr_data = rd_data | buf_mask;
               load_out        = 1'b1;
            end
         end
         ST_REJECT: begin
            if (out_free) begin
               load_out   = 1'b1;
               out_acc_in = 1'b0;
            end
         end
         ST_BASE: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
         end
         ST_SCAN: begin
            if (scan_step) begin
               if (dirty) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = idx_ff;
                  mem_req.wr_data = rd_data & ~(NUM_BUFS'(1) << cur_ff);
                  if (pend_vld_ff) begin
                     load_out    = 1'b1;
                     out_cv_in   = 1'b1;
                     out_idx_in  = pend_idx_ff;
                     out_src_in  = pend_src_ff;
                     out_dst_in  = pend_dst_ff;
                     out_cnt_in  = pend_cnt_ff;
                     out_last_in = 1'b0;
                  end
               end
               if (!scan_end) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff + CHUNK_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               load_out = 1'b1;
               if (pend_vld_ff) begin
                  out_cv_in  = 1'b1;
                  out_idx_in = pend_idx_ff;
                  out_src_in = pend_src_ff;
                  out_dst_in = pend_dst_ff;
                  out_cnt_in = pend_cnt_ff;
               end
            end
         end
         default: load_out = 1'b0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_BASE) begin
            pend_vld_ff <= 1'b0;
         end else if (scan_step && dirty) begin
            pend_vld_ff <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         chunk_ff <= req_chunk[CHUNK_W-1:0];
         bidx_ff  <= req_buffer_index;
      end
      if (state_ff == ST_SETUP) begin
         cur_ff   <= cur_calc;
         ppc_ff   <= ppc_calc;
         curcc_ff <= CURCC_W'(CURCC_W'(cur_calc) * CURCC_W'(cfg.chunk_count));
      end
      if (state_ff == ST_BASE) begin
         dst_ff   <= DST_W'(20'(curcc_ff) * 20'(ppc_ff));
         src_ff   <= '0;
         idx_ff   <= '0;
         count_ff <= '0;
      end else if (scan_step) begin
         if (dirty) begin
            pend_idx_ff <= idx_ff;
            pend_src_ff <= src_ff;
            pend_dst_ff <= dst_ff;
            pend_cnt_ff <= count_ff + COUNT_W'(1);
            count_ff    <= count_ff + COUNT_W'(1);
         end
         if (!scan_end) begin
            idx_ff <= idx_ff + CHUNK_W'(1);
            src_ff <= src_ff + SRC_W'(ppc_ff);
            dst_ff <= dst_ff + DST_W'(ppc_ff);
         end
      end
      if (load_out) begin
         out_acc_ff  <= out_acc_in;
         out_cv_ff   <= out_cv_in;
         out_idx_ff  <= out_idx_in;
         out_src_ff  <= out_src_in;
         out_dst_ff  <= out_dst_in;
         out_cnt_ff  <= out_cnt_in;
         out_last_ff <= out_last_in;
      end
   end

   assign req_stall         = state_ff != ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = out_acc_ff;
   assign rsp_copy_valid    = out_cv_ff;
   assign rsp_chunk_index   = out_idx_ff;
   assign rsp_source_offset = out_src_ff;
   assign rsp_dest_offset   = out_dst_ff;
   assign rsp_copied_count  = out_cnt_ff;
   assign rsp_last          = out_last_ff;

endmodule

`default_nettype wire

FILE: src/multi_buffer_dirty_chunk_tracker.sv
// Top level of the multi-buffer dirty chunk tracker.
// Instantiates mbdc_cfg, mbdc_dirty_store and mbdc_ctrl; uses mbdc_pkg.
`default_nettype none

// The tracker holds one dirty bit per chunk for each frame buffer in a 64-entry
// memory, one entry per chunk with one bit per buffer. For a mark beat the
// chunk's entry is read when the beat is accepted and written back, with the
// result, in the mark-write state once the output register is free. For a
// begin-frame beat a setup state and a base state work out the buffer and
// offsets, then the scan visits one chunk per cycle through the memory's single
// read port, unless a held copy command waits on a stalled output, and a closing
// flush state issues the final result. Input is stalled until the last
// result of a beat has been loaded into the output register. After reset and
// after every register write the dirty bits read as all set at once, by
// per-entry written flags, so no clearing pass is needed.
module multi_buffer_dirty_chunk_tracker
   import mbdc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [CFG_W-1:0]   csr_wdata,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic               req_mode,
   input  wire logic [7:0]         req_chunk,
   input  wire logic [7:0]         req_buffer_index,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic               rsp_accepted,
   output      logic               rsp_copy_valid,
   output      logic [CHUNK_W-1:0] rsp_chunk_index,
   output      logic [SRC_W-1:0]   rsp_source_offset,
   output      logic [DST_W-1:0]   rsp_dest_offset,
   output      logic [COUNT_W-1:0] rsp_copied_count,
   output      logic               rsp_last
);

   cfg_type             cfg;
   logic                setup_clear;
   mem_req_type         mem_req;
   logic [NUM_BUFS-1:0] rd_data;

   mbdc_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .setup_clear (setup_clear)
   );

   mbdc_dirty_store u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (setup_clear),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   mbdc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_chunk         (req_chunk),
      .req_buffer_index  (req_buffer_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_copy_valid    (rsp_copy_valid),
      .rsp_chunk_index   (rsp_chunk_index),
      .rsp_source_offset (rsp_source_offset),
      .rsp_dest_offset   (rsp_dest_offset),
      .rsp_copied_count  (rsp_copied_count),
      .rsp_last          (rsp_last),
      .mem_req           (mem_req),
      .rd_data           (rd_data)
   );

endmodule

`default_nettype wire

FILE: sim/mbdc_checker.sv
// Result checker for the multi-buffer dirty chunk tracker testbench.
// Watches the request, result and register ports, predicts every result beat
// and compares it with the block's output. Uses mbdc_pkg.
`default_nettype none

module mbdc_checker
   import mbdc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [CFG_W-1:0]   csr_wdata,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic               req_mode,
   input  wire logic [7:0]         req_chunk,
   input  wire logic [7:0]         req_buffer_index,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic               rsp_accepted,
   input  wire logic               rsp_copy_valid,
   input  wire logic [CHUNK_W-1:0] rsp_chunk_index,
   input  wire logic [SRC_W-1:0]   rsp_source_offset,
   input  wire logic [DST_W-1:0]   rsp_dest_offset,
   input  wire logic [COUNT_W-1:0] rsp_copied_count,
   input  wire logic               rsp_last,
   output int                      mismatch_count,
   output int                      copies_owed
);

   // One result beat, fields in port order.
   typedef struct packed {
      logic               accepted;
      logic               copy_valid;
      logic [CHUNK_W-1:0] chunk_index;
      logic [SRC_W-1:0]   source_offset;
      logic [DST_W-1:0]   dest_offset;
      logic [COUNT_W-1:0] copied_count;
      logic               last;
   } copy_cmd_type;

   // Shadow of the geometry in use and of the per-buffer dirty maps.
   logic [CFG_W-1:0]      chunks_used;
   logic [CFG_W-1:0]      batches_used;
   logic [CFG_W-1:0]      verts_used;
   logic [BUFCNT_W-1:0]   bufs_used;
   logic [NUM_CHUNKS-1:0] dirty_map [NUM_BUFS];
   copy_cmd_type          owed_results [$];
   int                    faults;

   // Register values outside their range are pulled to the nearest bound.
   function automatic logic [CFG_W-1:0] saturate(input logic [CFG_W-1:0] value,
                                                 input logic [CFG_W-1:0] top);
      if (value == '0) return CFG_W'(1);
      if (value > top) return top;
      return value;
   endfunction

   function automatic string show(input copy_cmd_type r);
      return $sformatf("acc=%0d copy=%0d chunk=%0d src=%0d dst=%0d count=%0d last=%0d",
                       r.accepted, r.copy_valid, r.chunk_index, r.source_offset,
                       r.dest_offset, r.copied_count, r.last);
   endfunction

   // Only the first ten faults are reported in full.
   task automatic log_fault(input string what);
      faults++;
      if (faults <= 10) $display("%s", what);
   endtask

   always @(posedge clock) begin
      copy_cmd_type got;
      copy_cmd_type want;
      copy_cmd_type cmd;
      int unsigned  sel;
      int unsigned  ppc;
      int unsigned  base;
      int unsigned  n;
      if (reset) begin
         chunks_used  = CFG_W'(1);
         batches_used = CFG_W'(1);
         verts_used   = CFG_W'(1);
         bufs_used    = BUFCNT_W'(1);
         for (int b = 0; b < NUM_BUFS; b++) dirty_map[b] = '1;
         owed_results.delete();
         faults = 0;
      end else begin
         // A register write is a fresh setup: every chunk of every buffer dirty again.
         if (csr_wr_en) begin
            case (reg_index_type'(csr_index))
               REG_CHUNK_COUNT: chunks_used  = saturate(csr_wdata, CHUNK_MAX);
               REG_BATCHES:     batches_used = saturate(csr_wdata, BATCH_MAX);
               REG_VERTS:       verts_used   = saturate(csr_wdata, VERTS_MAX);
               REG_BUF_COUNT: begin
                  bufs_used = BUFCNT_W'(saturate(CFG_W'(csr_wdata[BUFCNT_W-1:0]),
                                                 CFG_W'(BUFCNT_MAX)));
               end
               default: ;
            endcase
            for (int b = 0; b < NUM_BUFS; b++) dirty_map[b] = '1;
         end

         // Compare each accepted result beat with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_accepted, rsp_copy_valid, rsp_chunk_index, rsp_source_offset,
                   rsp_dest_offset, rsp_copied_count, rsp_last};
            if (owed_results.size() == 0) begin
               log_fault($sformatf("unexpected result beat: %s", show(got)));
            end else begin
               want = owed_results.pop_front();
               if (got !== want)
                  log_fault($sformatf("result mismatch: expected %s, got %s",
                                      show(want), show(got)));
            end
         end

         // Predict the results of each accepted request beat.
         if (req_valid && !req_stall) begin
            cmd = '0;
            cmd.last = 1'b1;
            if (req_mode) begin
               // Begin frame: scan the selected buffer in ascending chunk order.
               sel  = req_buffer_index % bufs_used;
               ppc  = ((32'(verts_used) + 1) / 2) * 32'(batches_used);
               base = sel * 32'(chunks_used) * ppc;
               n    = 0;
               cmd.accepted = 1'b1;
               for (int c = 0; c < NUM_CHUNKS; c++) begin
                  if (c < chunks_used && dirty_map[sel][c]) begin
                     dirty_map[sel][c] = 1'b0;
                     n++;
                     cmd.copy_valid    = 1'b1;
                     cmd.chunk_index   = CHUNK_W'(c);
                     cmd.source_offset = SRC_W'(c * ppc);
                     cmd.dest_offset   = DST_W'(base + c * ppc);
                     cmd.copied_count  = COUNT_W'(n);
                     cmd.last          = 1'b0;
                     owed_results.push_back(cmd);
                  end
               end
               if (n == 0) begin
                  owed_results.push_back(cmd);
               end else begin
                  cmd = owed_results.pop_back();
                  cmd.last = 1'b1;
                  owed_results.push_back(cmd);
               end
            end else begin
               // Mark: a chunk in range is set in every buffer in use.
               if (req_chunk < 8'(chunks_used)) begin
                  cmd.accepted = 1'b1;
                  for (int b = 0; b < NUM_BUFS; b++)
                     if (b < bufs_used) dirty_map[b][req_chunk[CHUNK_W-1:0]] = 1'b1;
               end
               owed_results.push_back(cmd);
            end
         end
      end
      mismatch_count <= faults;
      copies_owed    <= owed_results.size();
   end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench top for the multi-buffer dirty chunk tracker: clock, reset,
// register setup, request and result traffic, and the final verdict.
// Depends on mbdc_pkg, the tracker RTL and mbdc_checker.
`default_nettype none

module tb_top
   import mbdc_pkg::*;
();

   localparam logic        MODE_MARK    = 1'b0;
   localparam logic        MODE_FRAME   = 1'b1;
   localparam int unsigned LIMIT_CYCLES = 1_000_000;
   localparam int          HOLD_CYCLES  = 300;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [CFG_W-1:0]   csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic               req_mode;
   logic [7:0]         req_chunk;
   logic [7:0]         req_buffer_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_accepted;
   logic               rsp_copy_valid;
   logic [CHUNK_W-1:0] rsp_chunk_index;
   logic [SRC_W-1:0]   rsp_source_offset;
   logic [DST_W-1:0]   rsp_dest_offset;
   logic [COUNT_W-1:0] rsp_copied_count;
   logic               rsp_last;
   int                 mismatch_count;
   int                 copies_owed;

   // Traffic shaping for the request and result sides.
   logic idle_on;
   logic squeeze;
   int   chunks_in_use;

   multi_buffer_dirty_chunk_tracker dut (.*);

   mbdc_checker copy_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(LIMIT_CYCLES * 20);
      $display("[multi_buffer_dirty_chunk_tracker] ERROR");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off that backs the block up.
   initial begin : result_sink
      bit held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= idle_on && ($urandom_range(99) < 28);
      end
   end

   // Offer one request beat, after a random gap, and wait until it is taken.
   task automatic push_req(input logic mode, input logic [7:0] chunk,
                           input logic [7:0] buffer_index);
      while (idle_on && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_chunk        <= chunk;
      req_buffer_index <= buffer_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Write all four geometry registers, one per cycle.
   task automatic load_geometry(input logic [CFG_W-1:0] chunks, input logic [CFG_W-1:0] batches,
                                input logic [CFG_W-1:0] verts, input logic [CFG_W-1:0] bufs);
      csr_wr_en <= 1'b1;
      csr_index <= REG_CHUNK_COUNT;
      csr_wdata <= chunks;
      @(posedge clock);
      csr_index <= REG_BATCHES;
      csr_wdata <= batches;
      @(posedge clock);
      csr_index <= REG_VERTS;
      csr_wdata <= verts;
      @(posedge clock);
      csr_index <= REG_BUF_COUNT;
      csr_wdata <= bufs;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stop offering and wait until every predicted result beat has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (copies_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= REG_CHUNK_COUNT;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_mode         <= MODE_MARK;
      req_chunk        <= '0;
      req_buffer_index <= '0;
      idle_on          <= 1'b1;
      squeeze          <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: one chunk, one buffer; out-of-range marks are refused.
      push_req(MODE_FRAME, 8'd0, 8'd0);
      push_req(MODE_FRAME, 8'd0, 8'hFF);
      push_req(MODE_MARK, 8'd0, 8'd0);
      push_req(MODE_MARK, 8'd1, 8'd0);
      push_req(MODE_MARK, 8'hFF, 8'hFF);
      push_req(MODE_FRAME, 8'd0, 8'h80);

      // Largest geometry, written with values at or above the upper bounds.
      drain();
      load_geometry(7'd127, 7'd100, 7'd64, 7'h7F);
      push_req(MODE_FRAME, 8'd0, 8'hFF);
      push_req(MODE_FRAME, 8'd0, 8'd3);
      push_req(MODE_MARK, 8'd63, 8'd0);
      push_req(MODE_MARK, 8'd64, 8'd0);
      push_req(MODE_MARK, 8'd0, 8'd0);
      push_req(MODE_FRAME, 8'd0, 8'd0);
      push_req(MODE_FRAME, 8'd0, 8'd7);
      push_req(MODE_FRAME, 8'd0, 8'd2);

      // Zero in every register saturates to the lower bound.
      drain();
      load_geometry('0, '0, '0, '0);
      push_req(MODE_MARK, 8'd0, 8'd0);
      push_req(MODE_FRAME, 8'd0, 8'd1);

      // Odd vertex count: the packed size rounds up.
      drain();
      load_geometry(7'd5, 7'd3, 7'd3, 7'd3);
      push_req(MODE_FRAME, 8'd0, 8'd5);
      push_req(MODE_MARK, 8'd2, 8'd0);
      push_req(MODE_MARK, 8'd4, 8'd0);
      push_req(MODE_MARK, 8'd5, 8'd0);
      push_req(MODE_FRAME, 8'd0, 8'd2);
      push_req(MODE_FRAME, 8'd0, 8'd1);
      push_req(MODE_FRAME, 8'd0, 8'd0);

      // Random phases, each with its own geometry; phase four runs without gaps.
      for (int p = 0; p < 8; p++) begin
         drain();
         idle_on <= (p != 4);
         if (p == 2) squeeze <= 1'b1;
         case (p)
            0: begin
               chunks_in_use = 64;
               load_geometry(7'd64, 7'd64, 7'd64, 7'd4);
            end
            1: begin
               chunks_in_use = 1;
               load_geometry(7'd1, 7'd1, 7'd1, 7'd1);
            end
            5: begin
               chunks_in_use = 64;
               load_geometry(7'($urandom_range(65, 127)), 7'($urandom_range(65, 127)),
                             7'($urandom_range(65, 127)), 7'($urandom_range(5, 7)));
            end
            default: begin
               chunks_in_use = $urandom_range(1, 12);
               load_geometry(7'(chunks_in_use), 7'($urandom_range(1, 64)),
                             7'($urandom_range(1, 64)),
                             {4'($urandom), 3'($urandom_range(1, 4))});
            end
         endcase
         for (int i = 0; i < 28; i++) begin
            if ($urandom_range(99) < 30)
               push_req(MODE_FRAME, 8'($urandom), 8'($urandom));
            else if ($urandom_range(99) < 15)
               push_req(MODE_MARK, 8'($urandom), 8'($urandom));
            else
               push_req(MODE_MARK, 8'($urandom_range(chunks_in_use - 1)), 8'($urandom));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && copies_owed == 0) begin
         $display("[multi_buffer_dirty_chunk_tracker] OK");
      end else begin
         $display("[multi_buffer_dirty_chunk_tracker] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
src/mbdc_pkg.sv
src/mbdc_dirty_store.sv
src/mbdc_cfg.sv
src/mbdc_ctrl.sv
src/multi_buffer_dirty_chunk_tracker.sv
sim/mbdc_checker.sv
sim/tb_top.sv
